### rtl/sca_pkg.sv
// shared opcodes, error codes and types for the smallint checked alu
package sca_pkg;
   localparam int OpWidth = 4;
   localparam int InWidth = 16;
   localparam int OutWidth = 17;

   typedef enum logic [OpWidth-1:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_REM = 4'd4,
      OP_NEG = 4'd5, OP_ABS = 4'd6, OP_LT = 4'd7, OP_LE = 4'd8, OP_EQ = 4'd9,
      OP_NE = 4'd10, OP_GT = 4'd11, OP_GE = 4'd12, OP_SORT = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0, ERR_OVF = 2'd1, ERR_DIVZ = 2'd2
   } err_type;

   localparam logic [0:0] CSR_ERROR_MODE = 1'b0;
   localparam logic [0:0] CSR_NULL_CODE = 1'b1;
endpackage

### rtl/sca_div_cell.sv
// one restoring division step on magnitudes, passes the request down the chain
module sca_div_cell #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic [W-1:0] rem_in,
   input  logic [W-1:0] quo_in,
   input  logic [W-1:0] den_in,
   output logic [W-1:0] rem_ff,
   output logic [W-1:0] quo_ff
);
   logic [W:0] trial;
   logic [W-1:0] rem_in_n, quo_in_n;
   always_comb begin
      trial = {rem_in, quo_in[W-1]} - {1'b0, den_in};
      if (trial[W]) begin
         rem_in_n = {rem_in[W-2:0], quo_in[W-1]};
         quo_in_n = {quo_in[W-2:0], 1'b0};
      end else begin
         rem_in_n = trial[W-1:0];
         quo_in_n = {quo_in[W-2:0], 1'b1};
      end
   end
   always_ff @(posedge clock) begin
      rem_ff <= rem_in_n;
      quo_ff <= quo_in_n;
   end
endmodule

### rtl/smallint_checked_alu_core.sv
// top level of the smallint checked alu: decode, divider cell chain and result stage
//
// usage: drive req_opcode, req_operand_a and req_operand_b with start high;
// busy is always low, so a request is taken every cycle. each request gives
// exactly one result on rsp_result_value, rsp_is_null and rsp_error_code,
// marked by done for one cycle. every opcode takes the same path from start
// to done, set by the divider chain: one cell per quotient bit, one register
// stage before the chain and one after. throughput is one request per cycle.
// fast operations ride along beside the chain in delay registers so results
// stay in order.
// csr_we, csr_addr and csr_wdata write error_mode (index 0) and null_code
// (index 1) at the clock edge; write only while no request is in flight.
// reset clears the pipeline valid bits and sets error_mode to 0 and null_code
// to -32768. the receiver cannot stall; results must be taken when done.
module smallint_checked_alu_core #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [sca_pkg::OpWidth-1:0]    req_opcode,
   input  logic signed [sca_pkg::InWidth-1:0]  req_operand_a,
   input  logic signed [sca_pkg::InWidth-1:0]  req_operand_b,
   output logic                           done,
   output logic signed [sca_pkg::OutWidth-1:0] rsp_result_value,
   output logic                           rsp_is_null,
   output logic [1:0]                     rsp_error_code,
   input  logic                           csr_we,
   input  logic [0:0]                     csr_addr,
   input  logic [sca_pkg::InWidth-1:0]    csr_wdata
);
   import sca_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam int D = W + 1;

   typedef struct packed {
      logic                  fast;
      logic                  is_rem;
      logic                  q_neg;
      logic                  r_neg;
      logic                  ovf;
      logic [OutWidth-1:0]   value;
      logic                  is_null;
      logic [1:0]            err;
   } side_type;

   logic              mode_ff;
   logic [InWidth-1:0] null_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         null_ff <= {1'b1, {(InWidth-1){1'b0}}};
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ERROR_MODE: mode_ff <= csr_wdata[0];
            CSR_NULL_CODE:  null_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // sign-extend low W bits; wide enough for the sort difference too
   localparam int X = (W + 2 > OutWidth) ? W + 2 : OutWidth;
   logic signed [X-1:0] a_x, b_x, sum_x, dif_x;
   logic signed [W-1:0] a_w, b_w;
   logic [W-1:0] mag_a, mag_b;
   logic signed [2*W-1:0] prod;
   logic exc, bzero, amin;
   side_type side_in;

   function automatic logic [OutWidth-1:0] sx_out(input logic [W-1:0] v);
      logic signed [X-1:0] t;
      t = X'(signed'(v));
      return t[OutWidth-1:0];
   endfunction

   always_comb begin
      a_w = (W <= InWidth) ? W'(req_operand_a) : W'(req_operand_a);
      b_w = W'(req_operand_b);
      if (W > InWidth) begin
         a_w = W'(req_operand_a);
         b_w = W'(req_operand_b);
      end
      a_x = X'(a_w);
      b_x = X'(b_w);
      sum_x = a_x + b_x;
      dif_x = a_x - b_x;
      mag_a = a_w[W-1] ? W'(-a_w) : a_w;
      mag_b = b_w[W-1] ? W'(-b_w) : b_w;
      prod = (2*W)'(a_w) * (2*W)'(b_w);
      exc = ~mode_ff;
      bzero = (b_w == '0);
      amin = (a_w == {1'b1, {(W-1){1'b0}}});
      side_in = '0;
      side_in.fast = 1'b1;
      unique case (req_opcode)
         OP_ADD: begin
            side_in.value = sx_out(sum_x[W-1:0]);
            if (exc && (sum_x[W] != sum_x[W-1])) side_in.err = ERR_OVF;
         end
         OP_SUB: begin
            side_in.value = sx_out(dif_x[W-1:0]);
            if (exc && (dif_x[W] != dif_x[W-1])) side_in.err = ERR_OVF;
         end
         OP_MUL: begin
            side_in.value = sx_out(prod[W-1:0]);
            if (exc && (prod[2*W-1:W-1] != {(W+1){prod[W-1]}})) side_in.err = ERR_OVF;
         end
         OP_DIV, OP_REM: begin
            if (bzero) begin
               if (exc) side_in.err = ERR_DIVZ;
               else begin
                  side_in.value = OutWidth'(signed'(null_ff));
                  side_in.is_null = 1'b1;
               end
            end else begin
               side_in.fast = 1'b0;
               side_in.is_rem = (req_opcode == OP_REM);
               side_in.q_neg = a_w[W-1] ^ b_w[W-1];
               side_in.r_neg = a_w[W-1];
               side_in.ovf = amin && (b_w == '1);
            end
         end
         OP_NEG: begin
            side_in.value = sx_out(W'(-a_w));
            if (amin) side_in.err = ERR_OVF;
         end
         OP_ABS: begin
            side_in.value = sx_out(mag_a);
            if (amin && exc) side_in.err = ERR_OVF;
         end
         OP_LT: side_in.value = OutWidth'(a_w < b_w);
         OP_LE: side_in.value = OutWidth'(a_w <= b_w);
         OP_EQ: side_in.value = OutWidth'(a_w == b_w);
         OP_NE: side_in.value = OutWidth'(a_w != b_w);
         OP_GT: side_in.value = OutWidth'(a_w > b_w);
         OP_GE: side_in.value = OutWidth'(a_w >= b_w);
         OP_SORT: side_in.value = dif_x[OutWidth-1:0];
         default: ;
      endcase
   end

   // entry stage
   logic [D-1:0] vld_ff;
   side_type     side_ff [D];
   logic [W-1:0] num_ff, den_ff [W];
   logic [W-1:0] rem_c [W];
   logic [W-1:0] quo_c [W];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[D-2:0], start};
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      num_ff <= mag_a;
      den_ff[0] <= mag_b;
      for (int i = 1; i < D; i++) side_ff[i] <= side_ff[i-1];
      for (int i = 1; i < W; i++) den_ff[i] <= den_ff[i-1];
   end

   for (genvar g = 0; g < W; g++) begin : g_cell
      sca_div_cell #(.W(W)) u_cell (
         .clock (clock),
         .rem_in((g == 0) ? '0 : rem_c[g == 0 ? 0 : g-1]),
         .quo_in((g == 0) ? num_ff : quo_c[g == 0 ? 0 : g-1]),
         .den_in(den_ff[g]),
         .rem_ff(rem_c[g]),
         .quo_ff(quo_c[g])
      );
   end

   // output stage
   side_type st;
   logic [W-1:0] q_s, r_s;
   logic [OutWidth-1:0] val_ff;
   logic null_out_ff;
   logic [1:0] err_ff;
   logic done_ff;

   always_comb begin
      st = side_ff[D-1];
      q_s = st.q_neg ? W'(-quo_c[W-1]) : quo_c[W-1];
      r_s = st.r_neg ? W'(-rem_c[W-1]) : rem_c[W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= vld_ff[D-1];
      if (st.fast) begin
         val_ff <= st.value;
         null_out_ff <= st.is_null;
         err_ff <= st.err;
      end else begin
         val_ff <= st.is_rem ? sx_out(r_s) : sx_out(q_s);
         null_out_ff <= 1'b0;
         err_ff <= (!st.is_rem && st.ovf) ? ERR_OVF : ERR_NONE;
      end
   end

   assign done = done_ff;
   assign rsp_result_value = val_ff;
   assign rsp_is_null = null_out_ff;
   assign rsp_error_code = err_ff;

   a_null_no_err: assert property (@(posedge clock) disable iff (reset)
      done |-> !(rsp_is_null && rsp_error_code != ERR_NONE)) else $error("null with error");
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      done |-> rsp_error_code != 2'd3) else $error("bad error code");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff[0]) |-> ##(D) done) else $error("latency");
endmodule

### bench/tb_smallint_checked_alu_core.sv
// self-checking testbench for the smallint checked alu core with a built-in predictor
module tb_smallint_checked_alu_core;
   import sca_pkg::*;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [15:0] a;
      logic signed [15:0] b;
   } alu_req_type;

   typedef struct packed {
      logic signed [16:0] value;
      logic               is_null;
      logic [1:0]         err;
   } alu_rsp_type;

   localparam int Latency = 18;
   localparam int WatchLimit = 2000;

   logic clock, reset, start, busy, done, csr_we;
   logic [3:0] req_opcode;
   logic signed [15:0] req_operand_a, req_operand_b;
   logic signed [16:0] rsp_result_value;
   logic rsp_is_null;
   logic [1:0] rsp_error_code;
   logic [0:0] csr_addr;
   logic [15:0] csr_wdata;

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_rsps[$];
   logic mode_null;
   logic signed [15:0] null_value;
   int errors = 0;
   int idle_cycles = 0;
   bit quiet_stretch = 0;

   smallint_checked_alu_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .done(done),
      .rsp_result_value(rsp_result_value), .rsp_is_null(rsp_is_null),
      .rsp_error_code(rsp_error_code), .csr_we(csr_we), .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic alu_rsp_type predict_alu(alu_req_type r);
      alu_rsp_type o;
      logic signed [16:0] wide;
      logic signed [31:0] prod;
      logic signed [15:0] w;
      logic exc;
      exc = !mode_null;
      o = '0;
      case (r.opcode)
         OP_ADD: begin
            wide = r.a + r.b;
            w = wide[15:0];
            o.value = w;
            if (exc && wide != w) o.err = ERR_OVF;
         end
         OP_SUB: begin
            wide = r.a - r.b;
            w = wide[15:0];
            o.value = w;
            if (exc && wide != w) o.err = ERR_OVF;
         end
         OP_MUL: begin
            prod = r.a * r.b;
            w = prod[15:0];
            o.value = w;
            if (exc && prod != w) o.err = ERR_OVF;
         end
         OP_DIV, OP_REM: begin
            if (r.b == 0) begin
               if (exc) o.err = ERR_DIVZ;
               else begin
                  o.value = null_value;
                  o.is_null = 1;
               end
            end else if (r.a == -16'sd32768 && r.b == -16'sd1) begin
               if (r.opcode == OP_DIV) begin
                  o.value = r.a;
                  o.err = ERR_OVF;
               end
            end else begin
               w = (r.opcode == OP_DIV) ? r.a / r.b : r.a % r.b;
               o.value = w;
            end
         end
         OP_NEG: begin
            w = -r.a;
            o.value = w;
            if (r.a == -16'sd32768) o.err = ERR_OVF;
         end
         OP_ABS: begin
            w = r.a < 0 ? -r.a : r.a;
            o.value = w;
            if (exc && r.a == -16'sd32768) o.err = ERR_OVF;
         end
         OP_LT: o.value = r.a < r.b;
         OP_LE: o.value = r.a <= r.b;
         OP_EQ: o.value = r.a == r.b;
         OP_NE: o.value = r.a != r.b;
         OP_GT: o.value = r.a > r.b;
         OP_GE: o.value = r.a >= r.b;
         OP_SORT: o.value = 17'(r.a) - 17'(r.b);
         default: o = '0;
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(predict_alu('{req_opcode, req_operand_a, req_operand_b}));
            void'(pending_reqs.pop_front());
         end
         if (pending_reqs.size() > 0 && (quiet_stretch || $urandom_range(99) >= 32)) begin
            alu_req_type n;
            n = pending_reqs[0];
            start <= 1;
            req_opcode <= n.opcode;
            req_operand_a <= n.a;
            req_operand_b <= n.b;
         end else if (start && !busy) begin
            start <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && done) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response value %0d", $time, rsp_result_value);
            errors++;
         end else begin
            alu_rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_result_value !== e.value) begin
               $display("%0t: value expected %0d actual %0d", $time, e.value,
                        rsp_result_value);
               errors++;
            end
            if (rsp_is_null !== e.is_null) begin
               $display("%0t: is_null expected %0b actual %0b", $time, e.is_null,
                        rsp_is_null);
               errors++;
            end
            if (rsp_error_code !== e.err) begin
               $display("%0t: error_code expected %0d actual %0d", $time, e.err,
                        rsp_error_code);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic add_req(logic [3:0] op, logic signed [15:0] a, logic signed [15:0] b);
      pending_reqs.push_back('{op, a, b});
   endtask

   task automatic drain;
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= data;
      if (idx == CSR_ERROR_MODE) mode_null <= data[0];
      else null_value <= data;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic logic signed [15:0] pick_operand();
      case ($urandom_range(7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'($urandom_range(4)) - 16'sd2;
         3: return 16'($urandom_range(30)) - 16'sd15;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count);
      logic signed [15:0] b;
      repeat (count) begin
         b = pick_operand();
         add_req(4'($urandom_range(15)), pick_operand(), b);
      end
   endtask

   initial begin
      reset = 1;
      start = 0;
      csr_we = 0;
      csr_addr = '0;
      csr_wdata = '0;
      req_opcode = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      mode_null = 0;
      null_value = -16'sd32768;
      repeat (10) @(posedge clock);
      reset <= 0;

      add_req(OP_ADD, 16'sd32767, 16'sd1);
      add_req(OP_ADD, -16'sd32768, -16'sd1);
      add_req(OP_SUB, -16'sd32768, 16'sd1);
      add_req(OP_SUB, 16'sd32767, -16'sd1);
      add_req(OP_MUL, 16'sd256, 16'sd128);
      add_req(OP_MUL, -16'sd256, 16'sd128);
      add_req(OP_DIV, 16'sd7, 16'sd0);
      add_req(OP_REM, -16'sd7, 16'sd0);
      add_req(OP_DIV, -16'sd32768, -16'sd1);
      add_req(OP_REM, -16'sd32768, -16'sd1);
      add_req(OP_DIV, -16'sd7, 16'sd2);
      add_req(OP_REM, -16'sd7, 16'sd2);
      add_req(OP_NEG, -16'sd32768, 16'sd0);
      add_req(OP_ABS, -16'sd32768, 16'sd0);
      add_req(OP_ABS, -16'sd5, 16'sd0);
      for (int op = OP_LT; op <= OP_GE; op++) add_req(4'(op), -16'sd3, 16'sd3);
      add_req(OP_SORT, 16'sd32767, -16'sd32768);
      add_req(OP_SORT, -16'sd32768, 16'sd32767);
      add_req(4'd14, 16'sd1, 16'sd1);
      add_req(4'd15, -16'sd1, -16'sd1);
      drain();

      write_csr(CSR_ERROR_MODE, 16'd1);
      write_csr(CSR_NULL_CODE, 16'h7fff);
      add_req(OP_DIV, 16'sd7, 16'sd0);
      add_req(OP_ADD, 16'sd32767, 16'sd1);
      add_req(OP_NEG, -16'sd32768, 16'sd0);
      add_req(OP_ABS, -16'sd32768, 16'sd0);
      add_req(OP_DIV, -16'sd32768, -16'sd1);
      random_phase(150);
      drain();

      write_csr(CSR_NULL_CODE, 16'($urandom));
      random_phase(150);
      drain();

      write_csr(CSR_ERROR_MODE, 16'd0);
      quiet_stretch = 1;
      random_phase(150);
      drain();
      quiet_stretch = 0;

      write_csr(CSR_ERROR_MODE, 16'd1);
      write_csr(CSR_NULL_CODE, 16'h0000);
      random_phase(150);
      drain();

      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
